>>> design/gcs_pkg.sv
// ----------------------------------------------------------------------------
// gcs_pkg
// types and fixed constants shared by the glyph column segmenter modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gcs_pkg;

  // configuration port geometry
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // fixed field widths
  localparam int CFG_DIM_W = 13;
  localparam int PIXEL_W   = 32;
  localparam int INDEX_W   = 8;
  localparam int COORD_W   = 12;
  localparam int SIZE_W    = 13;

  // register reset values
  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 13'd256;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 13'd32;
  localparam logic [PIXEL_W-1:0]   BLANK_RST  = 32'd0;

  // register map, word index into the port
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BLANK  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] image_width;
    logic [CFG_DIM_W-1:0] image_height;
    logic [PIXEL_W-1:0]   blank_value;
  } cfg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] glyph_index;
    logic [COORD_W-1:0] left_x;
    logic [COORD_W-1:0] top_y;
    logic [SIZE_W-1:0]  box_width;
    logic [SIZE_W-1:0]  box_height;
  } res_t;

endpackage

`default_nettype wire

>>> design/gcs_regs.sv
// ----------------------------------------------------------------------------
// gcs_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcs_regs import gcs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= WIDTH_RST;
      cfg.image_height <= HEIGHT_RST;
      cfg.blank_value  <= BLANK_RST;
    end else if (wr_en) begin
      case (idx)
        REG_WIDTH:  cfg.image_width  <= pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT: cfg.image_height <= pwdata[CFG_DIM_W-1:0];
        REG_BLANK:  cfg.blank_value  <= pwdata[PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = DATA_W'(cfg.image_width);
      REG_HEIGHT: prdata = DATA_W'(cfg.image_height);
      REG_BLANK:  prdata = DATA_W'(cfg.blank_value);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/gcs_scan.sv
// ----------------------------------------------------------------------------
// gcs_scan
// scan position, glyph phase and running bounding box, one pixel per cycle while pixels transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcs_scan import gcs_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int MAX_GLYPHS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               in_xfer,
  input  wire logic [PIXEL_W-1:0] pixel,
  input  wire logic               image_start,
  output logic                    res_load,
  output res_t                    res
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int POS_W = $clog2(MAX_DIM);
  localparam int RW    = DIM_W + 1;
  localparam int EXT_W = (POS_W + 1 > SIZE_W) ? POS_W + 1 : SIZE_W;
  localparam int GCAP  = (MAX_GLYPHS - 1 < 255) ? MAX_GLYPHS - 1 : 255;
  localparam logic [INDEX_W-1:0] GLYPH_CAP = INDEX_W'(GCAP);
  localparam logic [31:0]        MAX_DIM_V = 32'(MAX_DIM);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) begin
      return DIM_W'(1);
    end else if (v32 > MAX_DIM_V) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(v32);
    end
  endfunction

  // state
  logic [DIM_W-1:0]   col_cnt;
  logic [POS_W-1:0]   row_cnt;
  logic               in_glyph;
  logic               col_ink;
  logic [POS_W-1:0]   box_left, box_top, box_bottom, box_right;
  logic [INDEX_W-1:0] glyph_cnt;

  logic [DIM_W-1:0]   col_cnt_next;
  logic [POS_W-1:0]   row_cnt_next;
  logic               in_glyph_next;
  logic               col_ink_next;
  logic [POS_W-1:0]   box_left_next, box_top_next, box_bottom_next, box_right_next;
  logic [INDEX_W-1:0] glyph_cnt_next;

  // start-adjusted view of the state
  logic [DIM_W-1:0]   col0;
  logic [POS_W-1:0]   row0;
  logic [POS_W-1:0]   col_pos;
  logic               ing0, ink0;
  logic [INDEX_W-1:0] gc0;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [RW-1:0]      row_inc;
  logic               active, ink, last, emit;
  logic [EXT_W-1:0]   left_ext, top_ext, width_ext, height_ext;

  always_comb begin
    w_eff   = clamp_dim(cfg.image_width);
    h_eff   = clamp_dim(cfg.image_height);
    col0    = image_start ? '0 : col_cnt;
    row0    = image_start ? '0 : row_cnt;
    ing0    = image_start ? 1'b0 : in_glyph;
    ink0    = image_start ? 1'b0 : col_ink;
    gc0     = image_start ? '0 : glyph_cnt;
    col_pos = POS_W'(col0);
    active  = col0 < w_eff;
    ink     = pixel != cfg.blank_value;
    row_inc = RW'(row0) + RW'(1);
    last    = row_inc >= RW'(h_eff);
    emit    = active && last && ing0 && !ink0 && !ink;

    col_cnt_next    = col0;
    row_cnt_next    = row0;
    in_glyph_next   = ing0;
    col_ink_next    = ink0;
    glyph_cnt_next  = gc0;
    box_left_next   = box_left;
    box_top_next    = box_top;
    box_bottom_next = box_bottom;
    box_right_next  = box_right;

    if (active) begin
      if (ink) begin
        if (!ing0) begin
          box_left_next   = col_pos;
          box_right_next  = col_pos;
          box_top_next    = row0;
          box_bottom_next = row0;
        end else begin
          if (row0 < box_top) begin
            box_top_next = row0;
          end
          if (row0 > box_bottom) begin
            box_bottom_next = row0;
          end
          if (col_pos > box_right) begin
            box_right_next = col_pos;
          end
        end
        in_glyph_next = 1'b1;
        col_ink_next  = 1'b1;
      end
      if (last) begin
        if (emit) begin
          in_glyph_next = 1'b0;
          if (gc0 < GLYPH_CAP) begin
            glyph_cnt_next = gc0 + INDEX_W'(1);
          end
        end
        col_ink_next = 1'b0;
        row_cnt_next = '0;
        col_cnt_next = col0 + DIM_W'(1);
      end else begin
        row_cnt_next = POS_W'(row_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt    <= '0;
      row_cnt    <= '0;
      in_glyph   <= 1'b0;
      col_ink    <= 1'b0;
      box_left   <= '0;
      box_top    <= '0;
      box_bottom <= '0;
      box_right  <= '0;
      glyph_cnt  <= '0;
    end else if (in_xfer) begin
      col_cnt    <= col_cnt_next;
      row_cnt    <= row_cnt_next;
      in_glyph   <= in_glyph_next;
      col_ink    <= col_ink_next;
      box_left   <= box_left_next;
      box_top    <= box_top_next;
      box_bottom <= box_bottom_next;
      box_right  <= box_right_next;
      glyph_cnt  <= glyph_cnt_next;
    end
  end

  // result fields come from the box as it stands, since the closing pixel is blank
  always_comb begin
    left_ext   = EXT_W'(box_left);
    top_ext    = EXT_W'(box_top);
    width_ext  = EXT_W'(box_right) - EXT_W'(box_left) + EXT_W'(1);
    height_ext = EXT_W'(box_bottom) - EXT_W'(box_top) + EXT_W'(1);
    res.glyph_index = gc0;
    res.left_x      = left_ext[COORD_W-1:0];
    res.top_y       = top_ext[COORD_W-1:0];
    res.box_width   = width_ext[SIZE_W-1:0];
    res.box_height  = height_ext[SIZE_W-1:0];
  end

  assign res_load = in_xfer && emit;

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    32'(col_cnt) <= MAX_DIM_V)
    else $error("column counter past the largest image width");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    in_glyph |-> (box_left <= box_right) && (box_top <= box_bottom))
    else $error("open glyph box is inverted");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    in_xfer && image_start |=> glyph_cnt == '0)
    else $error("glyph count not cleared by image start");

  a_emit_closes: assert property (@(posedge clk) disable iff (rst)
    res_load |=> !in_glyph && !col_ink && row_cnt == '0)
    else $error("glyph run still open after its box was reported");

endmodule

`default_nettype wire

>>> design/gcs_out_reg.sv
// ----------------------------------------------------------------------------
// gcs_out_reg
// result register with valid/ready handshake toward the consumer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcs_out_reg import gcs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic res_load,
  input  wire res_t res,
  input  wire logic out_ready,
  output logic      out_valid,
  output res_t      res_q,
  output logic      can_load
);

  // a new result may land when the slot is empty or drains this cycle
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

endmodule

`default_nettype wire

>>> design/glyph_column_segmenter.sv
// ----------------------------------------------------------------------------
// glyph_column_segmenter
// vertical-projection glyph finder for column-major sprite-sheet pixel streams
// ----------------------------------------------------------------------------
// latency: a glyph box is presented on the cycle after the transfer of the
//   last pixel of the first blank column that closes the run
// throughput: one pixel per cycle, set by the state update in the scan
//   unit; input stalls only while an unread result is held
// reset: synchronous, active high; scan at column 0 row 0, no open glyph,
//   glyph count 0, width 256, height 32, blank value 0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glyph_column_segmenter import gcs_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int MAX_GLYPHS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  // pixel stream
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [PIXEL_W-1:0] pixel,
  input  wire logic               image_start,
  // glyph boxes
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [INDEX_W-1:0] glyph_index,
  output logic      [COORD_W-1:0] left_x,
  output logic      [COORD_W-1:0] top_y,
  output logic      [SIZE_W-1:0]  box_width,
  output logic      [SIZE_W-1:0]  box_height
);

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic in_xfer;
  logic res_load;
  logic can_load;

  // registers must be held static while the scan runs; the block does not enforce this
  gcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a pixel transfers whenever one is offered and the result slot can take a box;
  // while a box waits to drain, every pixel is held off
  assign in_ready = can_load;
  assign in_xfer  = in_valid && in_ready;

  // per-pixel update: ink test, box growth, end-of-column check
  gcs_scan #(
    .MAX_DIM    (MAX_DIM),
    .MAX_GLYPHS (MAX_GLYPHS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_xfer     (in_xfer),
    .pixel       (pixel),
    .image_start (image_start),
    .res_load    (res_load),
    .res         (res)
  );

  // result register, loaded on the closing pixel's transfer
  gcs_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_q     (res_q),
    .can_load  (can_load)
  );

  assign glyph_index = res_q.glyph_index;
  assign left_x      = res_q.left_x;
  assign top_y       = res_q.top_y;
  assign box_width   = res_q.box_width;
  assign box_height  = res_q.box_height;

endmodule

`default_nettype wire

>>> tb/glyph_column_segmenter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_column_segmenter_test
// self-checking bench for the glyph column segmenter. Pixels stream in column
// by column under random gaps and back-pressure. A scan model inside the bench
// predicts every glyph box and each received box is compared field by field.
// A short table of hand-picked pixels opens the run. Random sprite sheets of
// small sizes follow, then a long one-row sheet that pins the glyph index.
// ----------------------------------------------------------------------------

module glyph_column_segmenter_test import gcs_pkg::*; ();

  localparam int DIM_LIMIT    = 4096;   // largest usable width and height
  localparam int INDEX_CAP    = 255;    // glyph index saturates here
  localparam int QUIET_CYCLES = 4;      // result shows in the cycle after its pixel
  localparam int LONG_HOLD    = 300;    // receiver stall that backs up the stream
  localparam int PLAN_ROWS    = 28;
  localparam int SAT_COLUMNS  = 2 * (INDEX_CAP + 1) + 8;  // enough one-column glyphs

  // ---------------------------------------------------------------------------
  // signals
  // ---------------------------------------------------------------------------
  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic [PIXEL_W-1:0] pixel;
  logic               image_start;
  logic               out_valid;
  logic               out_ready;
  logic [INDEX_W-1:0] glyph_index;
  logic [COORD_W-1:0] left_x;
  logic [COORD_W-1:0] top_y;
  logic [SIZE_W-1:0]  box_width;
  logic [SIZE_W-1:0]  box_height;

  glyph_column_segmenter DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // directed table: register writes and pixels, with the box typed in where it
  // is obvious from the picture
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {
    ROW_CFG,      // register write while idle
    ROW_PIXEL,    // pixel, box taken from the scan model
    ROW_CHECKED   // pixel whose transfer closes the typed-in box
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    reg_idx_t          sel;
    logic [DATA_W-1:0] data;
    bit                start;
    res_t              box;
  } plan_row_t;

  plan_row_t plan [PLAN_ROWS] = '{
    // 3 x 2 image, blank 0: glyph in column 0 row 1, closed by column 1
    '{ROW_CFG,     REG_WIDTH,  32'd3,          1'b0, '0},
    '{ROW_CFG,     REG_HEIGHT, 32'd2,          1'b0, '0},
    '{ROW_PIXEL,   REG_WIDTH,  32'h0000_0000,  1'b1, '0},
    '{ROW_PIXEL,   REG_WIDTH,  32'h0000_0005,  1'b0, '0},
    '{ROW_PIXEL,   REG_WIDTH,  32'h0000_0000,  1'b0, '0},
    '{ROW_CHECKED, REG_WIDTH,  32'h0000_0000,  1'b0,
      res_t'({8'd0, 12'd0, 12'd1, 13'd1, 13'd1})},
    // ink in the last column: run never closes and is dropped
    '{ROW_PIXEL,   REG_WIDTH,  32'hFFFF_FFFF,  1'b0, '0},
    '{ROW_PIXEL,   REG_WIDTH,  32'h0000_0000,  1'b0, '0},
    // scan finished, pixel ignored
    '{ROW_PIXEL,   REG_WIDTH,  32'hFFFF_FFFF,  1'b0, '0},
    // all-ones background, 2 x 2 glyph
    '{ROW_CFG,     REG_BLANK,  32'hFFFF_FFFF,  1'b0, '0},
    '{ROW_PIXEL,   REG_WIDTH,  32'h0000_0000,  1'b1, '0},
    '{ROW_PIXEL,   REG_WIDTH,  32'hFFFF_FFFF,  1'b0, '0},
    '{ROW_PIXEL,   REG_WIDTH,  32'hFFFF_FFFE,  1'b0, '0},
    '{ROW_PIXEL,   REG_WIDTH,  32'h0000_0001,  1'b0, '0},
    '{ROW_PIXEL,   REG_WIDTH,  32'hFFFF_FFFF,  1'b0, '0},
    '{ROW_CHECKED, REG_WIDTH,  32'hFFFF_FFFF,  1'b0,
      res_t'({8'd0, 12'd0, 12'd0, 13'd2, 13'd2})},
    // height lowered while row 2 of a column is next
    '{ROW_CFG,     REG_WIDTH,  32'd2,          1'b0, '0},
    '{ROW_CFG,     REG_HEIGHT, 32'd4,          1'b0, '0},
    '{ROW_CFG,     REG_BLANK,  32'h0000_0000,  1'b0, '0},
    '{ROW_PIXEL,   REG_WIDTH,  32'h0000_0007,  1'b1, '0},
    '{ROW_PIXEL,   REG_WIDTH,  32'h0000_0000,  1'b0, '0},
    '{ROW_CFG,     REG_HEIGHT, 32'd1,          1'b0, '0},
    '{ROW_PIXEL,   REG_WIDTH,  32'h0000_0000,  1'b0, '0},
    '{ROW_CHECKED, REG_WIDTH,  32'h0000_0000,  1'b0,
      res_t'({8'd0, 12'd0, 12'd0, 13'd1, 13'd1})},
    // widening after the scan ended picks up at the old width
    '{ROW_CFG,     REG_WIDTH,  32'd4,          1'b0, '0},
    '{ROW_PIXEL,   REG_WIDTH,  32'h0000_0003,  1'b0, '0},
    '{ROW_CHECKED, REG_WIDTH,  32'h0000_0000,  1'b0,
      res_t'({8'd1, 12'd2, 12'd0, 13'd1, 13'd1})},
    '{ROW_PIXEL,   REG_WIDTH,  32'hFFFF_FFFF,  1'b1, '0}
  };

  // ---------------------------------------------------------------------------
  // scan model state and bookkeeping
  // ---------------------------------------------------------------------------
  logic [CFG_DIM_W-1:0] cfg_width;
  logic [CFG_DIM_W-1:0] cfg_height;
  logic [PIXEL_W-1:0]   cfg_blank;

  int unsigned scan_col;
  int unsigned scan_row;
  bit          glyph_open;
  bit          col_inked;
  int unsigned run_left;
  int unsigned run_right;
  int unsigned run_top;
  int unsigned run_bottom;
  int unsigned glyph_count;

  res_t boxes_due[$];          // boxes predicted but not yet received

  int mismatches  = 0;
  int pixels_used = 0;         // pixels the scan actually consumed
  int tx_idle_pct = 10;        // chance of a gap before a pixel
  bit no_idle     = 1'b0;      // closing stretch: both sides at full rate
  bit hold_long   = 1'b0;      // ask the receiver for one long stall

  // zero acts as one, anything past the limit acts as the limit
  function automatic int unsigned usable_dim(input logic [CFG_DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return 32'(v);
  endfunction

  // a value that differs from the background, often in a single bit
  function automatic logic [PIXEL_W-1:0] ink_value();
    logic [PIXEL_W-1:0] v;
    if ($urandom_range(0, 1) == 0) return cfg_blank ^ (32'h1 << $urandom_range(0, 31));
    v = $urandom;
    while (v == cfg_blank) v = $urandom;
    return v;
  endfunction

  // advance the scan by one transferred pixel; returns 1 when a glyph closes
  function automatic bit segment_pixel(input logic [PIXEL_W-1:0] px, input bit st,
                                       output res_t box, output bit skipped);
    int unsigned w;
    int unsigned h;
    bit          closed;
    w       = usable_dim(cfg_width);
    h       = usable_dim(cfg_height);
    closed  = 1'b0;
    box     = '0;
    skipped = 1'b0;
    if (st) begin
      scan_col    = 0;
      scan_row    = 0;
      glyph_open  = 1'b0;
      col_inked   = 1'b0;
      glyph_count = 0;
    end
    // column counter parked at the width: image done, wait for a start
    if (scan_col >= w) begin
      skipped = 1'b1;
      return 1'b0;
    end
    if (px != cfg_blank) begin
      if (!glyph_open) begin
        glyph_open = 1'b1;
        run_left   = scan_col;
        run_right  = scan_col;
        run_top    = scan_row;
        run_bottom = scan_row;
      end else begin
        if (scan_row < run_top) run_top = scan_row;
        if (scan_row > run_bottom) run_bottom = scan_row;
        if (scan_col > run_right) run_right = scan_col;
      end
      col_inked = 1'b1;
    end
    // last row of the column, or past it after the height was lowered
    if (scan_row + 1 >= h) begin
      if (glyph_open && !col_inked) begin
        box.glyph_index = INDEX_W'(glyph_count);
        box.left_x      = COORD_W'(run_left);
        box.top_y       = COORD_W'(run_top);
        box.box_width   = SIZE_W'(run_right - run_left + 1);
        box.box_height  = SIZE_W'(run_bottom - run_top + 1);
        closed          = 1'b1;
        glyph_open      = 1'b0;
        if (glyph_count < INDEX_CAP) glyph_count++;
      end
      col_inked = 1'b0;
      scan_row  = 0;
      scan_col++;
    end else begin
      scan_row++;
    end
    return closed;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // drivers; every task starts and ends just after a falling edge
  // ---------------------------------------------------------------------------

  // configuration write: setup cycle, access cycle, then the port is deselected
  task automatic write_reg(input reg_idx_t sel, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(sel));
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (sel)
      REG_WIDTH:  cfg_width  = value[CFG_DIM_W-1:0];
      REG_HEIGHT: cfg_height = value[CFG_DIM_W-1:0];
      default:    cfg_blank  = value[PIXEL_W-1:0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // one pixel transfer; a typed-in box replaces the model's prediction
  task automatic send_pixel(input logic [PIXEL_W-1:0] px, input bit st,
                            input bit typed, input res_t typed_box);
    res_t box;
    bit   closed;
    bit   skipped;
    if (!no_idle && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    pixel       <= px;
    image_start <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    closed = segment_pixel(px, st, box, skipped);
    if (typed) begin
      closed = 1'b1;
      box    = typed_box;
    end
    if (closed) boxes_due.push_back(box);
    if (!skipped) pixels_used++;
    @(negedge clk);
  endtask

  // stop sending until every predicted box is back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (boxes_due.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // one sprite sheet at the current size; cut_after < 0 sends it whole
  task automatic send_image(input bit with_start, input int blank_col_pct,
                            input int ink_pct, input int cut_after);
    int unsigned        w;
    int unsigned        h;
    int                 sent;
    bit                 col_blank;
    logic [PIXEL_W-1:0] px;
    w    = usable_dim(cfg_width);
    h    = usable_dim(cfg_height);
    sent = 0;
    for (int c = 0; c < w; c++) begin
      col_blank = $urandom_range(0, 99) < blank_col_pct;
      for (int r = 0; r < h; r++) begin
        if (sent == cut_after) return;
        if (!col_blank && $urandom_range(0, 99) < ink_pct) px = ink_value();
        else px = cfg_blank;
        // stray noise pixel
        if ($urandom_range(0, 39) == 0) px = $urandom;
        send_pixel(px, with_start && sent == 0, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // dimension word, sometimes with junk above the register width
  function automatic logic [DATA_W-1:0] dim_word(input int top);
    logic [DATA_W-1:0] word;
    word = $urandom;
    if ($urandom_range(0, 3) != 0) word = '0;
    case ($urandom_range(0, 9))
      0:       word[CFG_DIM_W-1:0] = '0;
      1:       word[CFG_DIM_W-1:0] = 13'd1;
      default: word[CFG_DIM_W-1:0] = CFG_DIM_W'($urandom_range(2, top));
    endcase
    return word;
  endfunction

  // new small configuration, then a handful of images, mostly well formed
  task automatic random_phase(input bit hold);
    int unsigned area;
    int          images;
    drain();
    write_reg(REG_WIDTH, dim_word(10));
    write_reg(REG_HEIGHT, dim_word(6));
    case ($urandom_range(0, 3))
      0:       write_reg(REG_BLANK, 32'h0000_0000);
      1:       write_reg(REG_BLANK, 32'hFFFF_FFFF);
      default: write_reg(REG_BLANK, $urandom);
    endcase
    case ($urandom_range(0, 2))
      0:       tx_idle_pct = 0;
      1:       tx_idle_pct = 10;
      default: tx_idle_pct = 40;
    endcase
    if (hold) hold_long = 1'b1;
    area   = usable_dim(cfg_width) * usable_dim(cfg_height);
    images = $urandom_range(3, 8);
    repeat (images) begin
      case ($urandom_range(0, 9))
        0:       send_image(1'b1, 40, 40, $urandom_range(1, area));  // cut short
        1:       send_image(1'b0, 40, 40, -1);  // no start, scan carries on
        default: send_image(1'b1, 40, 40, -1);
      endcase
      // pixels past the end of the image
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) send_pixel($urandom, 1'b0, 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random ready bursts, one long stall on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_long = 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // box checker: each transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_boxes
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (boxes_due.size() == 0) begin
        report_mismatch($sformatf("box index %0d left %0d arrived with none pending",
                                  glyph_index, left_x));
      end else begin
        want = boxes_due.pop_front();
        if (glyph_index !== want.glyph_index)
          report_mismatch($sformatf("glyph_index %0d, want %0d",
                                    glyph_index, want.glyph_index));
        if (left_x !== want.left_x)
          report_mismatch($sformatf("left_x %0d, want %0d", left_x, want.left_x));
        if (top_y !== want.top_y)
          report_mismatch($sformatf("top_y %0d, want %0d", top_y, want.top_y));
        if (box_width !== want.box_width)
          report_mismatch($sformatf("box_width %0d, want %0d",
                                    box_width, want.box_width));
        if (box_height !== want.box_height)
          report_mismatch($sformatf("box_height %0d, want %0d",
                                    box_height, want.box_height));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    pixel       = '0;
    image_start = 1'b0;
    cfg_width   = WIDTH_RST;
    cfg_height  = HEIGHT_RST;
    cfg_blank   = BLANK_RST;
    scan_col    = 0;
    scan_row    = 0;
    glyph_open  = 1'b0;
    col_inked   = 1'b0;
    run_left    = 0;
    run_right   = 0;
    run_top     = 0;
    run_bottom  = 0;
    glyph_count = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].sel, plan[i].data);
      end else begin
        send_pixel(plan[i].data, plan[i].start, plan[i].kind == ROW_CHECKED, plan[i].box);
      end
    end

    // random sprite sheets; one phase runs into a long receiver stall
    phase = 0;
    while (phase < 2 || pixels_used < 150) begin
      random_phase(phase == 1);
      phase++;
    end

    // one row at clamped width and height: alternating ink and blank columns
    // close more glyphs than the index can count, so it saturates
    drain();
    tx_idle_pct = 10;
    write_reg(REG_WIDTH, 32'd8191);
    write_reg(REG_HEIGHT, 32'd0);
    write_reg(REG_BLANK, 32'h0000_0000);
    for (int c = 0; c < SAT_COLUMNS; c++) begin
      send_pixel(c[0] ? cfg_blank : ink_value(), c == 0, 1'b0, '0);
    end

    // closing stretch at full rate on both sides
    no_idle = 1'b1;
    random_phase(1'b0);
    drain();
    if (mismatches == 0) begin
      $display("[glyph_column_segmenter] OK");
    end else begin
      $display("[glyph_column_segmenter] ERROR");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #60_000_000;
    $display("[glyph_column_segmenter] ERROR");
    $finish;
  end

endmodule
